// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

   // Item kinds
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   // Register decode on address bits 15..11
   localparam logic [15:0] ADDR_MASK  = 16'hF800;
   localparam logic [15:0] ADDR_CHR0  = 16'h8800;
   localparam logic [15:0] ADDR_CHR1  = 16'h9800;
   localparam logic [15:0] ADDR_CHR2  = 16'hA800;
   localparam logic [15:0] ADDR_CHR3  = 16'hB800;
   localparam logic [15:0] ADDR_IRQLD = 16'hC800;
   localparam logic [15:0] ADDR_IRQEN = 16'hD800;
   localparam logic [15:0] ADDR_MIRR  = 16'hE800;
   localparam logic [15:0] ADDR_PRG   = 16'hF800;

   localparam int          IRQ_EN_BIT = 4;
   localparam logic [7:0]  IRQ_FIRE   = 8'hF6;
   localparam logic [1:0]  MIRR_MASK  = 2'h3;

   // CSR indexes
   localparam logic CSR_CHR_UNITS = 1'b0;
   localparam logic CSR_PRG_UNITS = 1'b1;

   localparam int PAGE_W  = 11;
   localparam int DVD_W   = 8;
   localparam int STEP_W  = 3;

   // Start command into the modulo unit
   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [PAGE_W-1:0] divisor;
   } mod_cmd_type;

   // Status back from the modulo unit
   typedef struct packed {
      logic              done;
      logic [PAGE_W-1:0] remainder;
   } mod_sts_type;

endpackage

// ===== rtl/cbm_req_if.sv =====
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  data;
   logic [8:0]  scanline;
   logic        rendering_enabled;

   modport source (output valid, action, address, data, scanline, rendering_enabled,
                   input ready);
   modport sink   (input valid, action, address, data, scanline, rendering_enabled,
                   output ready);
endinterface

// ===== rtl/cbm_rsp_if.sv =====
interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] chr_page_0;
   logic [10:0] chr_page_1;
   logic [10:0] chr_page_2;
   logic [10:0] chr_page_3;
   logic [7:0]  prg_page;
   logic [1:0]  mirroring;
   logic        irq_request;

   modport source (output valid, chr_page_0, chr_page_1, chr_page_2, chr_page_3,
                   prg_page, mirroring, irq_request, input ready);
   modport sink   (input valid, chr_page_0, chr_page_1, chr_page_2, chr_page_3,
                   prg_page, mirroring, irq_request, output ready);
endinterface

// ===== rtl/cbm_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// A zero divisor passes the dividend through.
module cbm_mod_unit
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_cmd_type cmd,
   output mod_sts_type sts
);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  shf_ff, shf_in;
   logic [PAGE_W-1:0] div_ff, div_in;
   logic [PAGE_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PAGE_W:0]   trial;

   // Command load, or one shift-compare-subtract step
   always_comb begin
      dvd_in  = dvd_ff;
      shf_in  = shf_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, shf_ff[DVD_W-1]};
      if (cmd.start) begin
         dvd_in  = cmd.dividend;
         shf_in  = cmd.dividend;
         div_in  = cmd.divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in  = trial[PAGE_W-1:0];
         shf_in  = {shf_ff[DVD_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      shf_ff <= shf_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign sts.done      = done_ff;
   assign sts.remainder = (div_ff == '0) ? PAGE_W'(dvd_ff) : rem_ff;

endmodule

// ===== rtl/cartridge_bank_mapper_scanline_irq.sv =====
// Cartridge bank mapper with a scanline interrupt counter. Each request is a
// bus write, a scanline tick or an init, and gives one response with the bank
// state after it. Writes to a character or program bank register reduce the
// doubled byte modulo the page count in a shared restoring remainder unit:
// such a request responds once the unit is done and the response slot is
// free. All other requests answer on the cycle after accept. One request is
// in work at a time; a new one is taken once the previous response has been
// taken or is leaving. Config registers (index 0 character ROM size, index 1
// program ROM size) are to be written by the user only while idle, which the
// block does not enforce; an init picks up the current character size.
module cartridge_bank_mapper_scanline_irq
   import cbm_pkg::*;
#(
   parameter int LAST_VISIBLE_LINE = 239
) (
   input  logic       clock,
   input  logic       reset,
   cbm_req_if.sink    req_if,
   cbm_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        chr_units_ff, prg_units_ff;
   logic [PAGE_W-1:0] chr_ff [4];
   logic [PAGE_W-1:0] chr_in [4];
   logic [7:0]        prg_ff, prg_in;
   logic [1:0]        mirr_ff, mirr_in;
   logic              irq_on_ff, irq_on_in;
   logic [7:0]        irq_cnt_ff, irq_cnt_in;
   logic [7:0]        irq_rld_ff, irq_rld_in;
   logic              irq_ff, irq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              tgt_prg_ff, tgt_prg_in;
   logic [1:0]        tgt_win_ff, tgt_win_in;
   mod_cmd_type       mod_cmd;
   mod_sts_type       mod_sts;
   logic              accept;
   logic              out_free;
   logic [15:0]       sel;
   logic [PAGE_W-1:0] last_page;
   logic [7:0]        cnt_dec;
   logic              tick_live;

   cbm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .sts   (mod_sts)
   );

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_if.valid && req_if.ready;
   assign sel          = req_if.address & ADDR_MASK;
   assign last_page    = {chr_units_ff, 3'b000};
   assign cnt_dec      = irq_cnt_ff - 8'd1;
   assign tick_live    = irq_on_ff && req_if.rendering_enabled &&
                         ({23'd0, req_if.scanline} <= 32'(LAST_VISIBLE_LINE));

   // Sequencer and bank state update
   always_comb begin
      state_in     = state_ff;
      chr_in       = chr_ff;
      prg_in       = prg_ff;
      mirr_in      = mirr_ff;
      irq_on_in    = irq_on_ff;
      irq_cnt_in   = irq_cnt_ff;
      irq_rld_in   = irq_rld_ff;
      irq_in       = irq_ff;
      tgt_prg_in   = tgt_prg_ff;
      tgt_win_in   = tgt_win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mod_cmd      = '{start: 1'b0,
                       dividend: {req_if.data[6:0], 1'b0},
                       divisor: (sel == ADDR_PRG) ?
                                {2'b00, prg_units_ff, 1'b0} : last_page};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               irq_in       = 1'b0;
               priority case (req_if.action)
                  ACT_WRITE: begin
                     priority case (sel)
                        ADDR_CHR0, ADDR_CHR1, ADDR_CHR2, ADDR_CHR3, ADDR_PRG: begin
                           // bank write: run the remainder unit first
                           mod_cmd.start = 1'b1;
                           tgt_prg_in    = (sel == ADDR_PRG);
                           tgt_win_in    = req_if.address[13:12];
                           rsp_valid_in  = 1'b0;
                           state_in      = ST_BUSY;
                        end
                        ADDR_IRQLD: begin
                           irq_cnt_in = irq_rld_ff;
                           irq_rld_in = req_if.data;
                        end
                        ADDR_IRQEN: irq_on_in = req_if.data[IRQ_EN_BIT];
                        ADDR_MIRR:  mirr_in   = (req_if.data[1:0] & MIRR_MASK) ^ 2'b01;
                        default: ;
                     endcase
                  end
                  ACT_TICK: begin
                     if (tick_live) begin
                        if (cnt_dec == IRQ_FIRE) begin
                           irq_cnt_in = irq_rld_ff;
                           irq_in     = 1'b1;
                        end else begin
                           irq_cnt_in = cnt_dec;
                        end
                     end
                  end
                  ACT_INIT: begin
                     chr_in[0]  = PAGE_W'(0);
                     chr_in[1]  = PAGE_W'(2);
                     chr_in[2]  = last_page - PAGE_W'(4);
                     chr_in[3]  = last_page - PAGE_W'(2);
                     prg_in     = '0;
                     irq_on_in  = 1'b0;
                     irq_cnt_in = '0;
                     irq_rld_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_BUSY: begin
            // commit the reduced page once the response slot is free
            if (mod_sts.done && out_free) begin
               if (tgt_prg_ff) begin
                  prg_in = mod_sts.remainder[7:0];
               end else begin
                  chr_in[tgt_win_ff] = mod_sts.remainder;
               end
               irq_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chr_units_ff <= 8'd1;
         prg_units_ff <= 8'd2;
         chr_ff[0]    <= PAGE_W'(0);
         chr_ff[1]    <= PAGE_W'(2);
         chr_ff[2]    <= PAGE_W'(4);
         chr_ff[3]    <= PAGE_W'(6);
         prg_ff       <= '0;
         mirr_ff      <= '0;
         irq_on_ff    <= 1'b0;
         irq_cnt_ff   <= '0;
         irq_rld_ff   <= '0;
         irq_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chr_ff       <= chr_in;
         prg_ff       <= prg_in;
         mirr_ff      <= mirr_in;
         irq_on_ff    <= irq_on_in;
         irq_cnt_ff   <= irq_cnt_in;
         irq_rld_ff   <= irq_rld_in;
         irq_ff       <= irq_in;
         // config writes
         if (csr_we) begin
            if (csr_index == CSR_CHR_UNITS) begin
               chr_units_ff <= csr_wdata;
            end else begin
               prg_units_ff <= csr_wdata;
            end
         end
      end
      tgt_prg_ff <= tgt_prg_in;
      tgt_win_ff <= tgt_win_in;
   end

   // Response is the committed bank state
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.chr_page_0  = chr_ff[0];
   assign rsp_if.chr_page_1  = chr_ff[1];
   assign rsp_if.chr_page_2  = chr_ff[2];
   assign rsp_if.chr_page_3  = chr_ff[3];
   assign rsp_if.prg_page    = prg_ff;
   assign rsp_if.mirroring   = mirr_ff;
   assign rsp_if.irq_request = irq_ff;

endmodule
